FILE: design/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg: shared constants and types for the scalar kalman filter
// Fixed-point formats, reset values and the divider status bundle.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAIN_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int GAIN_W    = GAIN_BITS + 1;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_BITS);

  // reset values follow the fraction width
  localparam logic [VAL_W-1:0] ONE_VAL       = VAL_W'(64'd1 << FRAC_BITS);
  localparam logic [VAL_W-1:0] PROC_NOISE_RST =
    VAL_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [VAL_W-1:0] MEAS_NOISE_RST = ONE_VAL;

  // register indexes (byte address bit 2)
  localparam logic REG_PROC_NOISE = 1'b0;
  localparam logic REG_MEAS_NOISE = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } skf_div_stat_t;

endpackage

FILE: design/skf_div.sv
// ----------------------------------------------------------------------------
// skf_div: restoring divider for the gain
// Produces floor(num * 2^GAIN_BITS / den) one quotient bit per cycle,
// given num <= den.
// ----------------------------------------------------------------------------
module skf_div
  import skf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [VAL_W-1:0]    num,
  input  logic [VAL_W:0]      den,
  output logic [GAIN_W-1:0]   quot,
  output skf_div_stat_t       stat
);

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic [VAL_W+1:0]  rem_r;
  logic [VAL_W:0]    den_r;
  logic [GAIN_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [VAL_W+2:0]  diff;
  logic              ge;
  logic [VAL_W+1:0]  rem_keep;

  always_comb begin
    diff     = {1'b0, rem_r} - {2'b00, den_r};
    ge       = ~diff[VAL_W+2];
    rem_keep = ge ? diff[VAL_W+1:0] : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(GAIN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {2'b00, num};
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      // remainder stays below den, so one left shift fits
      rem_r <= {rem_keep[VAL_W:0], 1'b0};
      q_r   <= {q_r[GAIN_W-2:0], ge};
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: design/scalar_kalman_filter_top.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top: one-dimensional kalman filter, fixed point
// Sequencer around a restoring divider and one shared multiplier.
// ----------------------------------------------------------------------------
// Each sample beat goes through these steps from acceptance until its result
// beat is offered: grow the covariance, launch the divider, run one divider
// iteration per bit of the 17-bit gain, take the gain, pass gain times
// residual and then one-minus-gain times covariance through the shared 18x34
// multiplier, and load the output register.
// in_tready is high only while the sequencer is idle, so a new sample is taken
// once the last has gone; a finished result waits in the output register, so
// the next sample may be taken before it is read, and that next sample holds
// in its last step until the waiting result is read. Noise registers sit on
// the APB port at byte addresses 0 (process noise) and 4 (measurement noise)
// and are meant to be written while the filter is idle.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top
  import skf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // sample beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [31:0] estimate, [48:32] gain, [80:49] covariance
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GROW  = 3'd1;
  localparam logic [2:0] S_DIVST = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL1  = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam int MA_W = GAIN_W + 1;
  localparam int MB_W = VAL_W + 2;
  localparam int PR_W = MA_W + MB_W;

  logic [2:0]          state_r, state_nxt;
  logic [VAL_W-1:0]    pnoise_r, mnoise_r;
  logic [VAL_W-1:0]    est_r, cov_r;
  logic [VAL_W-1:0]    z_r, p1_r;
  logic [GAIN_W-1:0]   k_r;
  logic                den_zero_r;
  logic signed [PR_W-1:0] prod_r;

  logic [VAL_W-1:0]    out_est_r, out_cov_r;
  logic [GAIN_W-1:0]   out_gain_r;
  logic                out_valid_r;

  logic [VAL_W:0]      grow_sum;
  logic [VAL_W:0]      den;
  logic [VAL_W:0]      resid;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PR_W-1:0] mul_p;
  logic                div_start;
  logic [GAIN_W-1:0]   div_quot;
  skf_div_stat_t       div_st;
  logic                cfg_wr;
  logic                out_load;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_MEAS_NOISE) ? mnoise_r : pnoise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pnoise_r <= PROC_NOISE_RST;
      mnoise_r <= MEAS_NOISE_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_PROC_NOISE) begin
        pnoise_r <= cfg_pwdata;
      end else begin
        mnoise_r <= cfg_pwdata;
      end
    end
  end

  // datapath helpers
  always_comb begin
    grow_sum = {1'b0, cov_r} + {1'b0, pnoise_r};
    den      = {1'b0, p1_r} + {1'b0, mnoise_r};
    resid    = {z_r[VAL_W-1], z_r} - {est_r[VAL_W-1], est_r};
  end

  // shared multiplier operand select
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = $signed({1'b0, k_r});
      mul_b = $signed({resid[VAL_W], resid});
    end else begin
      mul_a = $signed({1'b0, GAIN_ONE - k_r});
      mul_b = $signed({2'b00, p1_r});
    end
    mul_p = mul_a * mul_b;
  end

  assign div_start = (state_r == S_DIVST);

  skf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (p1_r),
    .den   (den),
    .quot  (div_quot),
    .stat  (div_st)
  );

  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_GROW;
      S_GROW:  state_nxt = S_DIVST;
      S_DIVST: state_nxt = S_DIV;
      S_DIV:   if (div_st.done) state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_FIN;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      est_r       <= '0;
      cov_r       <= ONE_VAL;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_MUL2) begin
        // prod_r holds k * residual; arithmetic shift gives the floor
        est_r <= est_r + prod_r[GAIN_BITS+VAL_W-1:GAIN_BITS];
      end
      if (out_load) begin
        cov_r       <= prod_r[GAIN_BITS+VAL_W-1:GAIN_BITS];
        out_valid_r <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      z_r <= in_tdata;
    end
    if (state_r == S_GROW) begin
      p1_r <= grow_sum[VAL_W] ? '1 : grow_sum[VAL_W-1:0];
    end
    if (state_r == S_DIVST) begin
      den_zero_r <= (den == '0);
    end
    if ((state_r == S_DIV) && div_st.done) begin
      k_r <= den_zero_r ? '0 : div_quot;
    end
    if ((state_r == S_MUL1) || (state_r == S_MUL2)) begin
      prod_r <= mul_p;
    end
    if (out_load) begin
      out_est_r  <= est_r;
      out_gain_r <= k_r;
      out_cov_r  <= prod_r[GAIN_BITS+VAL_W-1:GAIN_BITS];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_cov_r, out_gain_r, out_est_r};

`ifndef SYNTH
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL1) |-> (k_r <= GAIN_ONE))
    else $error("gain above one");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_tvalid && (state_r == S_IDLE)))
    else $error("result not offered after load");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> !in_tready)
    else $error("sample accepted while dividing");
`endif

endmodule

FILE: bench/skf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_checker: result checker for the scalar kalman filter
// Watches the sample, result and apb channels, keeps its own copy of the
// noise registers and the filter state, predicts every update and compares
// each result beat field by field in order.
// ----------------------------------------------------------------------------
module skf_checker
  import skf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          mismatch_count,
  output int          updates_in_flight
);

  typedef struct packed {
    logic [31:0]       estimate;
    logic [GAIN_W-1:0] gain;
    logic [31:0]       covariance;
  } filter_update_t;

  localparam logic [2:0] ADDR_PROC_NOISE = {REG_PROC_NOISE, 2'b00};
  localparam logic [2:0] ADDR_MEAS_NOISE = {REG_MEAS_NOISE, 2'b00};

  logic signed [31:0] est_state;
  logic [31:0]        cov_state;
  logic [31:0]        proc_noise;
  logic [31:0]        meas_noise;
  filter_update_t     pending_updates[$];
  filter_update_t     next_update;
  filter_update_t     oldest_update;
  filter_update_t     seen_update;

  // one filter step: grow covariance, gain, move estimate, shrink covariance
  function automatic filter_update_t kalman_update(input logic signed [31:0] z,
                                                   input logic signed [31:0] x,
                                                   input logic [31:0] p,
                                                   input logic [31:0] q,
                                                   input logic [31:0] r);
    longint unsigned grown;
    longint unsigned divisor;
    longint unsigned k;
    longint unsigned shrunk;
    longint          residual;
    longint          moved;
    filter_update_t  upd;
    grown = 64'(p) + 64'(q);
    if (grown > 64'hFFFF_FFFF) grown = 64'hFFFF_FFFF;
    divisor = grown + 64'(r);
    k = 0;
    if (divisor != 0) k = (grown << GAIN_BITS) / divisor;
    if (k > 64'(GAIN_ONE)) k = 64'(GAIN_ONE);
    residual = longint'(z) - longint'(x);
    // arithmetic shift of the signed product floors toward minus infinity
    moved = longint'(x) + ((longint'(k) * residual) >>> GAIN_BITS);
    shrunk = ((64'(GAIN_ONE) - k) * grown) >> GAIN_BITS;
    upd.estimate   = moved[31:0];
    upd.gain       = k[GAIN_W-1:0];
    upd.covariance = shrunk[31:0];
    return upd;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  initial begin
    mismatch_count    = 0;
    updates_in_flight = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      est_state  = '0;
      cov_state  = ONE_VAL;
      proc_noise = PROC_NOISE_RST;
      meas_noise = MEAS_NOISE_RST;
      pending_updates.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr == ADDR_PROC_NOISE) proc_noise = cfg_pwdata;
          else if (cfg_paddr == ADDR_MEAS_NOISE) meas_noise = cfg_pwdata;
        end else if (cfg_paddr == ADDR_PROC_NOISE) begin
          check_field("process noise read", proc_noise, cfg_prdata);
        end else if (cfg_paddr == ADDR_MEAS_NOISE) begin
          check_field("measure noise read", meas_noise, cfg_prdata);
        end
      end
      // results come from earlier samples, so retire before taking a new one
      if (out_tvalid && out_tready) begin
        seen_update.estimate   = out_tdata[31:0];
        seen_update.gain       = out_tdata[48:32];
        seen_update.covariance = out_tdata[80:49];
        if (pending_updates.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result beat with none pending, actual %h", $time, seen_update);
        end else begin
          oldest_update = pending_updates.pop_front();
          check_field("estimate", oldest_update.estimate, seen_update.estimate);
          check_field("gain", 32'(oldest_update.gain), 32'(seen_update.gain));
          check_field("covariance", oldest_update.covariance, seen_update.covariance);
        end
      end
      if (in_tvalid && in_tready) begin
        next_update = kalman_update(in_tdata, est_state, cov_state, proc_noise, meas_noise);
        pending_updates.push_back(next_update);
        est_state = next_update.estimate;
        cov_state = next_update.covariance;
      end
    end
    updates_in_flight = pending_updates.size();
  end

endmodule

FILE: bench/scalar_kalman_filter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top_tb: testbench for the scalar kalman filter
// Drives directed extremes and long random sample streams under several
// noise settings, with bursty samples, a stalling result side and long
// hold-offs; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top_tb;
  import skf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_SAMPLES  = 160;

  localparam logic [2:0] ADDR_PROC_NOISE = {REG_PROC_NOISE, 2'b00};
  localparam logic [2:0] ADDR_MEAS_NOISE = {REG_MEAS_NOISE, 2'b00};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] sample
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;  // [31:0] estimate, [48:32] gain, [80:49] covariance
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          mismatch_count;
  int          updates_in_flight;
  int          quiet_cycles;
  int          burst_left;
  int          hold_requests;
  int          holds_done;
  logic [31:0] drift_base;

  scalar_kalman_filter_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  skf_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready),
    .mismatch_count    (mismatch_count),
    .updates_in_flight (updates_in_flight)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // nothing accepted for too long means the filter is stuck
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: stall modes that change now and then, plus requested hold-offs
  initial begin
    int ready_mode;
    int mode_left;
    out_tready = 1'b0;
    holds_done = 0;
    mode_left  = 0;
    ready_mode = 0;
    forever begin
      @(negedge clk);
      if (hold_requests > holds_done) begin
        holds_done++;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(10, 120);
      end
      mode_left--;
      case (ready_mode)
        0: out_tready = 1'b1;
        1: out_tready = 1'($urandom_range(0, 1));
        default: out_tready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = write;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // one sample beat; bursts of random length separated by random gaps
  task automatic send_sample(input logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      in_tvalid = 1'b0;
      in_tdata  = $urandom;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tdata  = value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (updates_in_flight != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_noise(input logic [31:0] q, input logic [31:0] r);
    wait_idle();
    apb_access(1'b1, ADDR_PROC_NOISE, q);
    apb_access(1'b1, ADDR_MEAS_NOISE, r);
    apb_access(1'b0, ADDR_PROC_NOISE, '0);
    apb_access(1'b0, ADDR_MEAS_NOISE, '0);
  endtask

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      7: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        // slowly drifting signal with a little measurement noise
        drift_base = drift_base + $urandom_range(0, 32'h0000_3FFF) - 32'h0000_2000;
        return drift_base + $urandom_range(0, 32'h0000_FFFF) - 32'h0000_8000;
      end
    endcase
  endfunction

  initial begin
    logic [31:0] directed[$];
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    quiet_cycles  = 0;
    burst_left    = 0;
    hold_requests = 0;
    drift_base    = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset values of the noise registers, then extremes at default noise
    apb_access(1'b0, ADDR_PROC_NOISE, '0);
    apb_access(1'b0, ADDR_MEAS_NOISE, '0);
    directed = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
    foreach (directed[i]) send_sample(directed[i]);

    // no noise: gain of one empties the covariance, then the divisor is zero
    set_noise(32'h0, 32'h0);
    directed = '{32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
    foreach (directed[i]) send_sample(directed[i]);

    // covariance growth saturates
    set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    directed = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    foreach (directed[i]) send_sample(directed[i]);
    set_noise(32'hFFFF_FFFF, 32'h0);
    directed = '{32'h7FFF_FFFF, 32'h8000_0000};
    foreach (directed[i]) send_sample(directed[i]);

    // tiny gain against a huge measurement noise
    set_noise(32'h1, 32'hFFFF_FFFF);
    directed = '{32'h7FFF_FFFF, 32'h8000_0000};
    foreach (directed[i]) send_sample(directed[i]);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) set_noise(PROC_NOISE_RST, MEAS_NOISE_RST);
      else set_noise(pick_noise(), pick_noise());
      if (phase == 1 || phase == 4) hold_requests++;
      repeat (PHASE_SAMPLES) send_sample(pick_sample());
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/skf_pkg.sv
design/skf_div.sv
design/scalar_kalman_filter_top.sv
bench/skf_checker.sv
bench/scalar_kalman_filter_top_tb.sv
